>>> rtl/rit_pkg.sv
`default_nettype none

package rit_pkg;

    localparam int RAM_WORDS = 128;
    localparam int RAM_AW    = $clog2(RAM_WORDS);
    localparam int TIMER_W   = 18;
    localparam int DATA_W    = 8;

    // item kinds
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // register selectors (address bits 2:0 in the register window)
    localparam logic [2:0] SEL_PORT_A     = 3'd0;
    localparam logic [2:0] SEL_DIR_A      = 3'd1;
    localparam logic [2:0] SEL_PORT_B     = 3'd2;
    localparam logic [2:0] SEL_DIR_B      = 3'd3;
    localparam logic [2:0] SEL_TIMER      = 3'd4;
    localparam logic [2:0] SEL_TIMER_ALT  = 3'd6;

    localparam logic [TIMER_W-1:0] TIMER_RESET = TIMER_W'(255);

    // shift for prescale 1, 8, 64, 1024
    function automatic logic [3:0] rit_shift(input logic [1:0] sel);
        logic [3:0] sh;
        begin
            case (sel)
                2'd0:    sh = 4'd0;
                2'd1:    sh = 4'd3;
                2'd2:    sh = 4'd6;
                default: sh = 4'd10;
            endcase
            return sh;
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/rit_ram.sv
`default_nettype none

module rit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        // hold read data unless a new read is issued
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/ram_io_timer_chip.sv
// RAM, I/O and interval timer block. Each input item is a timer tick, a bus
// read or a bus write, carried with the current levels of the port A and
// port B pins. A new item is taken every clock cycle unless the input stalls;
// only a bus read yields a result item, which passes the synchronous RAM read
// and first stage, then the output register. The 128-byte RAM is a single
// synchronous memory with one write and one read port, and
// that memory port pair sets the rate of one item per cycle. RAM contents
// read as zero after reset through a per-entry valid bit, so no clearing
// pass is needed and items are taken from the first cycle after reset.
// Register reads (port mix, direction, timer, flag) are resolved when the
// item is accepted, so later ticks or writes never disturb a pending result.
// The input stalls only while a read result waits in the first stage behind
// a result that the output side stalls. The timer counts down once per
// accepted tick and holds at zero, setting the underflow flag; the IRQ
// enable bit is stored but drives nothing.
`default_nettype none

module ram_io_timer_chip
    import rit_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  operation,
    input  wire logic [15:0] address,
    input  wire logic [7:0]  write_data,
    input  wire logic [7:0]  port_a_pins,
    input  wire logic [7:0]  port_b_pins,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       read_data
);

    // architectural state
    logic [DATA_W-1:0]  dir_a_reg, dir_a_next;
    logic [DATA_W-1:0]  dir_b_reg, dir_b_next;
    logic [DATA_W-1:0]  out_a_reg, out_a_next;
    logic [DATA_W-1:0]  out_b_reg, out_b_next;
    logic [1:0]         prescale_sel_reg, prescale_sel_next;
    logic [TIMER_W-1:0] timer_count_reg, timer_count_next;
    logic               irq_enable_reg, irq_enable_next;
    logic               flag_reg, flag_next;
    logic [RAM_WORDS-1:0] ram_valid_reg, ram_valid_next;

    // read pipeline
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_is_ram_reg;
    logic              s1_ram_ok_reg;
    logic [DATA_W-1:0] s1_reg_data_reg;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] read_data_reg;

    logic              in_accept;
    logic              s1_adv;
    logic              is_regs;
    logic              is_timer_wr;
    logic              timer_wr;
    logic [RAM_AW-1:0] ram_idx;
    logic              ram_we;
    logic              ram_re;
    logic [DATA_W-1:0] ram_rdata;
    logic [TIMER_W-1:0] timer_shifted;
    logic [DATA_W-1:0] timer_val;
    logic [DATA_W-1:0] reg_rd;

    // ------------------------------------------------------------------
    // Decode
    // ------------------------------------------------------------------
    assign in_accept   = in_valid && !in_stall;
    assign is_regs     = address[9] && !address[7];
    assign is_timer_wr = address[4] && address[2];
    assign timer_wr    = in_accept && (operation == OP_WRITE) && is_regs && is_timer_wr;
    assign ram_idx     = address[RAM_AW-1:0];
    assign ram_we      = in_accept && (operation == OP_WRITE) && !is_regs;
    assign ram_re      = in_accept && (operation == OP_READ) && !is_regs;

    // ------------------------------------------------------------------
    // Handshake: the only backpressure is a pending read that cannot move
    // ------------------------------------------------------------------
    assign s1_adv   = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !s1_adv;

    // ------------------------------------------------------------------
    // RAM
    // ------------------------------------------------------------------
    rit_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RAM_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_idx),
        .wdata (write_data),
        .re    (ram_re),
        .raddr (ram_idx),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Register read value, resolved at acceptance
    // ------------------------------------------------------------------
    assign timer_shifted = timer_count_reg >> rit_shift(prescale_sel_reg);
    assign timer_val     = timer_shifted[DATA_W-1:0];

    always_comb
    begin
        case (address[2:0])
            SEL_PORT_A:
            begin
                reg_rd = (port_a_pins & ~dir_a_reg) | (out_a_reg & dir_a_reg);
            end
            SEL_DIR_A:
            begin
                reg_rd = dir_a_reg;
            end
            SEL_PORT_B:
            begin
                reg_rd = (port_b_pins & ~dir_b_reg) | (out_b_reg & dir_b_reg);
            end
            SEL_DIR_B:
            begin
                reg_rd = dir_b_reg;
            end
            SEL_TIMER, SEL_TIMER_ALT:
            begin
                reg_rd = timer_val;
            end
            default:
            begin
                // interrupt flag view: flag in bit 7
                reg_rd = timer_val | {flag_reg, {(DATA_W-1){1'b0}}};
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State update
    // ------------------------------------------------------------------
    always_comb
    begin
        dir_a_next        = dir_a_reg;
        dir_b_next        = dir_b_reg;
        out_a_next        = out_a_reg;
        out_b_next        = out_b_reg;
        prescale_sel_next = prescale_sel_reg;
        timer_count_next  = timer_count_reg;
        irq_enable_next   = irq_enable_reg;
        flag_next         = flag_reg;
        ram_valid_next    = ram_valid_reg;

        if (ram_we)
        begin
            ram_valid_next[ram_idx] = 1'b1;
        end

        if (in_accept)
        begin
            case (operation)
                OP_TICK:
                begin
                    // advance the timer; hold at zero and raise the flag
                    if (timer_count_reg != '0)
                    begin
                        timer_count_next = timer_count_reg - TIMER_W'(1);
                    end
                    else
                    begin
                        flag_next = 1'b1;
                    end
                end
                OP_READ:
                begin
                    // reading the plain timer view drops the flag
                    if (is_regs && (address[2:0] inside {SEL_TIMER, SEL_TIMER_ALT}))
                    begin
                        flag_next = 1'b0;
                    end
                end
                OP_WRITE:
                begin
                    if (is_regs)
                    begin
                        if (is_timer_wr)
                        begin
                            irq_enable_next   = address[3];
                            prescale_sel_next = address[1:0];
                            timer_count_next  = {{(TIMER_W-DATA_W){1'b0}}, write_data}
                                                << rit_shift(address[1:0]);
                            flag_next         = 1'b0;
                        end
                        else
                        begin
                            case (address[2:0])
                                SEL_PORT_A: out_a_next = write_data;
                                SEL_DIR_A:  dir_a_next = write_data;
                                SEL_PORT_B: out_b_next = write_data;
                                SEL_DIR_B:  dir_b_next = write_data;
                                default:    ;
                            endcase
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Read pipeline control
    // ------------------------------------------------------------------
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = s1_valid_reg;
        end
        // the first stage loads whenever it is empty or moves on
        if (s1_adv || !s1_valid_reg)
        begin
            s1_valid_next = in_accept && (operation == OP_READ);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_a_reg        <= '0;
            dir_b_reg        <= '0;
            out_a_reg        <= '0;
            out_b_reg        <= '0;
            prescale_sel_reg <= '0;
            timer_count_reg  <= TIMER_RESET;
            irq_enable_reg   <= 1'b0;
            flag_reg         <= 1'b0;
            ram_valid_reg    <= '0;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            dir_a_reg        <= dir_a_next;
            dir_b_reg        <= dir_b_next;
            out_a_reg        <= out_a_next;
            out_b_reg        <= out_b_next;
            prescale_sel_reg <= prescale_sel_next;
            timer_count_reg  <= timer_count_next;
            irq_enable_reg   <= irq_enable_next;
            flag_reg         <= flag_next;
            ram_valid_reg    <= ram_valid_next;
            s1_valid_reg     <= s1_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload of the read pipeline
    always_ff @(posedge clk)
    begin
        if (in_accept && (operation == OP_READ))
        begin
            s1_is_ram_reg   <= !is_regs;
            s1_ram_ok_reg   <= ram_valid_reg[ram_idx];
            s1_reg_data_reg <= reg_rd;
        end
        if (s1_adv && s1_valid_reg)
        begin
            if (s1_is_ram_reg)
            begin
                // never-written entries read as zero
                read_data_reg <= s1_ram_ok_reg ? ram_rdata : '0;
            end
            else
            begin
                read_data_reg <= s1_reg_data_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;

`ifndef NO_ASSERTIONS
    a_stall_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with no pending read");

    a_pending_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> s1_valid_reg)
        else $error("pending read dropped while output stalled");

    a_flag_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(flag_reg) |-> (timer_count_reg == '0))
        else $error("underflow flag set with nonzero count");

    a_count_rises_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        (timer_count_reg > $past(timer_count_reg)) |-> $past(timer_wr))
        else $error("timer count rose without a timer load");
`endif

endmodule

`default_nettype wire

>>> sim/ram_io_timer_checker.sv
`timescale 1ns / 100ps

module ram_io_timer_checker
    import rit_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [1:0]  operation,
    input  wire logic [15:0] address,
    input  wire logic [7:0]  write_data,
    input  wire logic [7:0]  port_a_pins,
    input  wire logic [7:0]  port_b_pins,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [7:0]  read_data,
    output int               errors,
    output int               reads_due
);

    // address bits 4 and 2 both set mark a timer load
    localparam logic [4:0] TIMER_LOAD_KEY = 5'h14;

    logic [DATA_W-1:0]  ram_copy [RAM_WORDS];
    logic [7:0]         ddr_a;
    logic [7:0]         ddr_b;
    logic [7:0]         latch_a;
    logic [7:0]         latch_b;
    logic [1:0]         presc;
    logic [TIMER_W-1:0] count;
    logic               irq_en;
    logic               uflag;
    logic [DATA_W-1:0]  read_bytes_due [$];

    function automatic int presc_shift(input logic [1:0] sel);
        case (sel)
            2'd0:    return 0;
            2'd1:    return 3;
            2'd2:    return 6;
            default: return 10;
        endcase
    endfunction

    // Advance the shadow chip by one accepted item; queue the byte a read returns.
    task automatic apply_bus_item(input logic [1:0] op, input logic [15:0] addr,
                                  input logic [7:0] wdata, input logic [7:0] pa,
                                  input logic [7:0] pb);
        logic [10:0] a;
        logic        in_regs;
        logic [7:0]  v;
        a       = addr[10:0];
        in_regs = a[9] && !a[7];
        v       = '0;
        case (op)
            OP_TICK:
            begin
                if (count != '0)
                    count = count - 1'b1;
                else
                    uflag = 1'b1;
            end
            OP_READ:
            begin
                if (!in_regs)
                    v = ram_copy[a[6:0]];
                else
                begin
                    case (a[2:0])
                        SEL_PORT_A:    v = (pa & ~ddr_a) | (latch_a & ddr_a);
                        SEL_DIR_A:     v = ddr_a;
                        SEL_PORT_B:    v = (pb & ~ddr_b) | (latch_b & ddr_b);
                        SEL_DIR_B:     v = ddr_b;
                        SEL_TIMER,
                        SEL_TIMER_ALT:
                        begin
                            v     = 8'(count >> presc_shift(presc));
                            uflag = 1'b0;
                        end
                        default:       v = 8'(count >> presc_shift(presc)) | {uflag, 7'd0};
                    endcase
                end
                read_bytes_due.push_back(v);
            end
            OP_WRITE:
            begin
                if (!in_regs)
                    ram_copy[a[6:0]] = wdata;
                else if ((a[4:0] & TIMER_LOAD_KEY) == TIMER_LOAD_KEY)
                begin
                    irq_en = a[3];
                    presc  = a[1:0];
                    count  = TIMER_W'(wdata) << presc_shift(a[1:0]);
                    uflag  = 1'b0;
                end
                else
                begin
                    case (a[2:0])
                        SEL_PORT_A: latch_a = wdata;
                        SEL_DIR_A:  ddr_a   = wdata;
                        SEL_PORT_B: latch_b = wdata;
                        SEL_DIR_B:  ddr_b   = wdata;
                        default:    ;
                    endcase
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [7:0] want;
        if (!rst_n)
        begin
            for (int i = 0; i < RAM_WORDS; i++)
                ram_copy[i] = '0;
            ddr_a   = '0;
            ddr_b   = '0;
            latch_a = '0;
            latch_b = '0;
            presc   = '0;
            count   = TIMER_W'(255);
            irq_en  = 1'b0;
            uflag   = 1'b0;
            errors  = 0;
            read_bytes_due.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                apply_bus_item(operation, address, write_data, port_a_pins, port_b_pins);
            if (out_valid && !out_stall)
            begin
                if (read_bytes_due.size() == 0)
                begin
                    $display("%0t: read_data %02h arrived with no read outstanding",
                             $time, read_data);
                    errors++;
                end
                else
                begin
                    want = read_bytes_due.pop_front();
                    if (read_data !== want)
                    begin
                        $display("%0t: read_data mismatch, expected %02h, got %02h",
                                 $time, want, read_data);
                        errors++;
                    end
                end
            end
        end
        reads_due = read_bytes_due.size();
    end

endmodule

>>> sim/tb_ram_io_timer_chip.sv
`timescale 1ns / 100ps

module tb_ram_io_timer_chip;
    import rit_pkg::*;

    // the one operation code the chip ignores
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int RANDOM_ITEMS = 1430;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  operation;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  port_a_pins;
    logic [7:0]  port_b_pins;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  read_data;

    int errors;
    int reads_due;
    int stall_left = 0;
    bit steady     = 1'b0;   // set for stretches that run with no idling at all

    ram_io_timer_chip u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .address     (address),
        .write_data  (write_data),
        .port_a_pins (port_a_pins),
        .port_b_pins (port_b_pins),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_data   (read_data)
    );

    // Shadow model and scoreboard sit beside the chip and watch both channels.
    ram_io_timer_checker u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .address     (address),
        .write_data  (write_data),
        .port_a_pins (port_a_pins),
        .port_b_pins (port_b_pins),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_data   (read_data),
        .errors      (errors),
        .reads_due   (reads_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop: far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    // Pick an idle length: mostly none or a few cycles, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // Stall the result side in bursts; changes land on the falling edge.
    always @(negedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else
            stall_left = pick_gap();
        out_stall = (stall_left > 0);
    end

    // Present one item, hold it until the chip takes it, return at a falling edge.
    task automatic send_item(input logic [1:0] op, input logic [15:0] addr,
                             input logic [7:0] wdata, input logic [7:0] pa,
                             input logic [7:0] pb);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        operation   = op;
        address     = addr;
        write_data  = wdata;
        port_a_pins = pa;
        port_b_pins = pb;
        in_valid    = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        int          counted;
        int          iter;
        int          kind;
        int          region;
        int          sub;
        int          drain;
        logic [1:0]  op;
        logic [15:0] addr;
        logic [7:0]  wdata;

        // Drive every input to a known level before anything else happens.
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        operation   = OP_TICK;
        address     = '0;
        write_data  = '0;
        port_a_pins = '0;
        port_b_pins = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: RAM after reset, the RAM mirror with high address bits
        // set, both ports mixing pins and latches, the timer running out and
        // holding at zero, the flag cleared by one read selector and not the
        // other, the slowest prescale, an ignored register write and the
        // ignored operation.
        send_item(OP_READ,  16'h0000, 8'h00, 8'h00, 8'h00);
        send_item(OP_WRITE, 16'h0000, 8'hFF, 8'hFF, 8'hFF);
        send_item(OP_READ,  16'hF880, 8'h00, 8'h00, 8'h00);
        send_item(OP_WRITE, 16'h007F, 8'h5A, 8'h00, 8'h00);
        send_item(OP_READ,  16'h02FF, 8'h00, 8'h00, 8'h00);
        send_item(OP_WRITE, 16'h0201, 8'hF0, 8'h00, 8'h00);
        send_item(OP_WRITE, 16'h0200, 8'hAA, 8'h00, 8'h00);
        send_item(OP_READ,  16'h0200, 8'h00, 8'h55, 8'h00);
        send_item(OP_WRITE, 16'h0203, 8'hFF, 8'h00, 8'h00);
        send_item(OP_WRITE, 16'h0202, 8'h3C, 8'h00, 8'h00);
        send_item(OP_READ,  16'h0202, 8'h00, 8'h00, 8'hC3);
        send_item(OP_READ,  16'h0201, 8'h00, 8'hFF, 8'hFF);
        send_item(OP_READ,  16'h0203, 8'h00, 8'h00, 8'h00);
        send_item(OP_READ,  16'h0204, 8'h00, 8'h00, 8'h00);
        send_item(OP_WRITE, 16'h0214, 8'h02, 8'h00, 8'h00);
        repeat (3)
            send_item(OP_TICK, 16'h0000, 8'h00, 8'h00, 8'h00);
        send_item(OP_READ,  16'h0205, 8'h00, 8'h00, 8'h00);
        send_item(OP_READ,  16'h0206, 8'h00, 8'h00, 8'h00);
        send_item(OP_READ,  16'h0207, 8'h00, 8'h00, 8'h00);
        send_item(OP_WRITE, 16'h021F, 8'hFF, 8'h00, 8'h00);
        send_item(OP_READ,  16'h021D, 8'h00, 8'h00, 8'h00);
        send_item(OP_WRITE, 16'h0205, 8'h77, 8'h00, 8'h00);
        send_item(OP_NONE,  16'hFFFF, 8'hFF, 8'hFF, 8'hFF);

        // Random part: ticks, reads and writes spread over RAM, its mirror and
        // the register window. Timer loads are mostly small so the count runs
        // out often and the flag logic gets exercised.
        counted = 0;
        iter    = 0;
        while (counted < RANDOM_ITEMS)
        begin
            if (iter % 64 == 0)
                steady = ($urandom_range(3) == 0);
            iter++;

            kind   = $urandom_range(99);
            region = $urandom_range(9);
            addr   = 16'($urandom);
            wdata  = 8'($urandom);

            if (kind < 2)
                op = OP_NONE;
            else if (kind < 45)
                op = OP_TICK;
            else if (kind < 78)
                op = OP_READ;
            else
                op = OP_WRITE;

            if (region < 4)
                addr[9] = 1'b0;
            else if (region < 6)
            begin
                addr[9] = 1'b1;
                addr[7] = 1'b1;
            end
            else
            begin
                addr[9] = 1'b0 | 1'b1;
                addr[7] = 1'b0;
                if (op == OP_WRITE)
                begin
                    sub = $urandom_range(9);
                    if (sub < 4)
                    begin
                        // timer load; keep the count short most of the time
                        addr[4] = 1'b1;
                        addr[2] = 1'b1;
                        if ($urandom_range(3) != 0)
                        begin
                            wdata     = 8'($urandom_range(0, 20));
                            addr[1]   = 1'b0;
                        end
                    end
                    else if (sub < 9)
                        addr[2] = 1'b0;
                end
            end

            send_item(op, addr, wdata, 8'($urandom), 8'($urandom));
            if (op != OP_NONE)
                counted++;
        end
        steady   = 1'b0;
        in_valid = 1'b0;

        // Drain: let outstanding reads come back, then a few more cycles.
        drain = 0;
        while (reads_due != 0 && drain < 4000)
        begin
            @(negedge clk);
            drain++;
        end
        repeat (8) @(negedge clk);

        if (reads_due != 0)
            $display("%0t: %0d read results never arrived", $time, reads_due);
        if (errors == 0 && reads_due == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> files.f
rtl/rit_pkg.sv
rtl/rit_ram.sv
rtl/ram_io_timer_chip.sv
sim/ram_io_timer_checker.sv
sim/tb_ram_io_timer_chip.sv
